// ----- design/tgpr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgpr_pkg
// Shared types and constants of the text glyph pixel renderer.
// ----------------------------------------------------------------------------
package tgpr_pkg;

    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 8;
    localparam int GLYPH_COUNT  = 128;

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int GI_W        = $clog2(GLYPH_COUNT);
    localparam int GX_W        = $clog2(GLYPH_WIDTH);
    localparam int GY_W        = $clog2(GLYPH_HEIGHT);
    localparam int FC_W        = $clog2(GLYPH_HEIGHT + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int COL_W   = 9;
    localparam int ROW_W   = 9;
    localparam int COLS_W  = 10;
    localparam int COLOR_W = 24;
    localparam int PIX_W   = 12;
    localparam int STORE_W = 8;

    localparam logic [ROW_W-1:0]  ROW_MAX = 9'd511;
    localparam logic [COLS_W-1:0] COL_MAX = 10'd512;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS  = 2'd0;
    localparam logic [1:0] CFG_FG_COLOR = 2'd1;
    localparam logic [1:0] CFG_BG_COLOR = 2'd2;

    localparam logic [COLS_W-1:0]  COLUMNS_RESET  = 10'd100;
    localparam logic [COLOR_W-1:0] FG_COLOR_RESET = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BG_COLOR_RESET = 24'h000000;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PRINT = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NEWLINE  = 8'h0a;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
    localparam logic [7:0] CH_LOWER_LO = 8'h61;
    localparam logic [7:0] CH_LOWER_HI = 8'h7f;
    localparam logic [7:0] UPPER_BASE  = 8'd10;
    localparam logic [7:0] LOWER_BASE  = 8'd36;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [6:0] glyph_index;
        logic [2:0] glyph_row;
        logic [7:0] row_bits;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [GI_W-1:0]  glyph;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_job;

    typedef struct packed {
        logic               en;
        logic [SA_W-1:0]    addr;
        logic [STORE_W-1:0] data;
    } t_wr_req;

endpackage

// ----- design/text_glyph_pixel_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// text_glyph_pixel_renderer_unit
// Terminal character renderer: loads glyph rows and draws characters as pixels.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  output   | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A drawn character first reads its rows through the single glyph store read
// port, then emits one pixel per cycle while the output is not stalled.
// A short job queue lets the front keep taking items while pixels drain; a
// load waits until all queued glyphs have fetched their rows.
// Reset is synchronous and clears the cursor and the registers; the glyph
// store holds no reset value. The output register lets pixels stall freely.
// ----------------------------------------------------------------------------
module text_glyph_pixel_renderer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tgpr_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tgpr_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tgpr_pkg::COLOR_W-1:0]  i_cfg_data
);
    import tgpr_pkg::*;

    logic [COLS_W-1:0]  r_columns;
    logic [COLOR_W-1:0] r_fg_color;
    logic [COLOR_W-1:0] r_bg_color;

    t_wr_req            wr;
    logic               push_valid;
    logic               push_ready;
    t_job               push_job;
    logic               pop_valid;
    logic               pop_ready;
    t_job               pop_job;
    logic               fetch_busy;
    logic               pending;
    logic               rd_en;
    logic [SA_W-1:0]    rd_addr;
    logic [STORE_W-1:0] rd_data;

    assign o_cfg_ready = 1'b1;
    assign pending     = pop_valid || fetch_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns  <= COLUMNS_RESET;
            r_fg_color <= FG_COLOR_RESET;
            r_bg_color <= BG_COLOR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLUMNS:  r_columns  <= i_cfg_data[COLS_W-1:0];
                CFG_FG_COLOR: r_fg_color <= i_cfg_data;
                CFG_BG_COLOR: r_bg_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tgpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_columns    (r_columns),
        .i_pending    (pending),
        .o_wr         (wr),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_job   (push_job)
    );

    tgpr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    tgpr_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tgpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (pop_valid),
        .o_job_ready  (pop_ready),
        .i_job        (pop_job),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .i_fg_color   (r_fg_color),
        .i_bg_color   (r_bg_color),
        .o_fetch_busy (fetch_busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- design/tgpr_ram.sv -----
// ----------------------------------------------------------------------------
// tgpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tgpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/tgpr_front.sv -----
// ----------------------------------------------------------------------------
// tgpr_front
// Accepts items, writes glyph rows, moves the text cursor and queues glyphs.
// ----------------------------------------------------------------------------
module tgpr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tgpr_pkg::t_in_item          i_in_data,
    input  logic [tgpr_pkg::COLS_W-1:0] i_columns,
    input  logic                        i_pending,
    output tgpr_pkg::t_wr_req           o_wr,
    output logic                        o_push_valid,
    input  logic                        i_push_ready,
    output tgpr_pkg::t_job              o_push_job
);
    import tgpr_pkg::*;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic              is_print;
    logic [7:0]        code;
    logic [7:0]        glyph;
    logic              in_map;
    logic              mapped;
    logic              accept;
    logic              load_ok;
    logic [COLS_W-1:0] limit;
    logic [COLS_W-1:0] step_col;
    logic [ROW_W-1:0]  step_row;

    assign is_print = (i_in_data.command == CMD_PRINT);
    assign code     = i_in_data.char_code;

    always_comb begin
        glyph  = 8'd0;
        in_map = 1'b0;
        if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
            glyph  = code - CH_UPPER_A + UPPER_BASE;
            in_map = 1'b1;
        end else if (code >= CH_DIGIT_0 && code <= CH_DIGIT_9) begin
            glyph  = code - CH_DIGIT_0;
            in_map = 1'b1;
        end else if (code >= CH_LOWER_LO && code <= CH_LOWER_HI) begin
            glyph  = code - CH_LOWER_LO + LOWER_BASE;
            in_map = 1'b1;
        end
    end

    assign mapped = in_map && (32'(glyph) < GLYPH_COUNT);

    // A load waits until every queued glyph has read its rows from the store.
    always_comb begin
        if (!is_print) begin
            o_in_ready = !i_pending;
        end else if (mapped) begin
            o_in_ready = i_push_ready;
        end else begin
            o_in_ready = 1'b1;
        end
    end

    assign accept  = i_in_valid && o_in_ready;
    assign load_ok = (32'(i_in_data.glyph_index) < GLYPH_COUNT)
                  && (32'(i_in_data.glyph_row) < GLYPH_HEIGHT);

    assign o_wr.en   = accept && !is_print && load_ok;
    assign o_wr.addr = SA_W'(32'(i_in_data.glyph_index) * GLYPH_HEIGHT
                             + 32'(i_in_data.glyph_row));
    assign o_wr.data = i_in_data.row_bits;

    assign o_push_valid     = i_in_valid && is_print && mapped;
    assign o_push_job.glyph = GI_W'(glyph);
    assign o_push_job.col   = r_col;
    assign o_push_job.row   = r_row;

    always_comb begin
        if (i_columns == '0) begin
            limit = COLS_W'(1);
        end else if (i_columns > COL_MAX) begin
            limit = COL_MAX;
        end else begin
            limit = i_columns;
        end

        if (code == CH_NEWLINE) begin
            step_col = '0;
            step_row = (r_row == ROW_MAX) ? r_row : r_row + 1'b1;
        end else begin
            step_col = {1'b0, r_col} + 1'b1;
            step_row = r_row;
        end

        if (step_col >= limit) begin
            n_col = '0;
            n_row = (step_row == ROW_MAX) ? step_row : step_row + 1'b1;
        end else begin
            n_col = step_col[COL_W-1:0];
            n_row = step_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && is_print) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- design/tgpr_queue.sv -----
// ----------------------------------------------------------------------------
// tgpr_queue
// Short queue of glyph render jobs between the front and the back.
// ----------------------------------------------------------------------------
module tgpr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  tgpr_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output tgpr_pkg::t_job o_pop_job
);
    import tgpr_pkg::*;

    t_job             r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != QC_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/tgpr_back.sv -----
// ----------------------------------------------------------------------------
// tgpr_back
// Fetches a glyph's rows and emits its pixels, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module tgpr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    output logic                         o_job_ready,
    input  tgpr_pkg::t_job               i_job,
    output logic                         o_rd_en,
    output logic [tgpr_pkg::SA_W-1:0]    o_rd_addr,
    input  logic [tgpr_pkg::STORE_W-1:0] i_rd_data,
    input  logic [tgpr_pkg::COLOR_W-1:0] i_fg_color,
    input  logic [tgpr_pkg::COLOR_W-1:0] i_bg_color,
    output logic                         o_fetch_busy,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tgpr_pkg::t_out_item          o_out_data
);
    import tgpr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    logic [SA_W-1:0]        r_base_addr;
    logic [PIX_W-1:0]       r_base_x;
    logic [PIX_W-1:0]       r_base_y;
    logic [FC_W-1:0]        r_cnt;
    logic [GX_W-1:0]        r_gx;
    logic [GY_W-1:0]        r_gy;
    logic [GLYPH_WIDTH-1:0] r_rows [GLYPH_HEIGHT];
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [FC_W-1:0]        cnt_m1;
    logic                   pix_last;
    logic                   pix_set;

    assign cnt_m1   = r_cnt - 1'b1;
    assign pix_last = (r_gx == GX_W'(GLYPH_WIDTH - 1)) && (r_gy == GY_W'(GLYPH_HEIGHT - 1));
    assign pix_set  = r_rows[r_gy][r_gx];

    assign o_job_ready  = (r_state == ST_IDLE);
    assign o_fetch_busy = (r_state == ST_FETCH);
    assign o_rd_en      = (r_state == ST_FETCH) && (r_cnt < FC_W'(GLYPH_HEIGHT));
    assign o_rd_addr    = r_base_addr + SA_W'(r_cnt);
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    // The read issued at count k returns at count k+1 and lands in row k.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_gx        <= '0;
            r_gy        <= '0;
        end else begin
            // While emitting, the pixel register is either held or reloaded.
            if (r_out_valid && i_out_ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_base_addr <= SA_W'(32'(i_job.glyph) * GLYPH_HEIGHT);
                        r_base_x    <= PIX_W'(i_job.col) * PIX_W'(GLYPH_WIDTH);
                        r_base_y    <= PIX_W'(i_job.row) * PIX_W'(GLYPH_HEIGHT);
                        r_cnt       <= '0;
                        r_state     <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    if (r_cnt != '0) begin
                        r_rows[cnt_m1[GY_W-1:0]] <= i_rd_data[GLYPH_WIDTH-1:0];
                    end
                    if (r_cnt == FC_W'(GLYPH_HEIGHT)) begin
                        r_gx    <= '0;
                        r_gy    <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out.pixel_x <= r_base_x + PIX_W'(r_gx);
                        r_out.pixel_y <= r_base_y + PIX_W'(r_gy);
                        r_out.color   <= pix_set ? i_fg_color : i_bg_color;
                        r_out.last    <= pix_last;
                        if (r_gy == GY_W'(GLYPH_HEIGHT - 1)) begin
                            r_gy <= '0;
                            r_gx <= r_gx + 1'b1;
                        end else begin
                            r_gy <= r_gy + 1'b1;
                        end
                        if (pix_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
